FILE: hdl/fpi_pkg.sv
// Shared types, vowel tables and interpolation arithmetic for the formant interpolator.
package fpi_pkg;

  localparam int NUM_FORMANTS = 4;
  localparam int NUM_STYLES   = 2;
  localparam int NUM_VOWELS   = 5;
  localparam int CORNERS      = 4;
  localparam int VAL_W        = 18;
  localparam int FRAC_W       = 16;

  localparam logic [14:0] CENTER_NOTE_RST = 15'd20480;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [1:0]              formant_t;
  typedef logic [2:0]              vowel_t;

  localparam formant_t LAST_FORMANT = formant_t'(NUM_FORMANTS - 1);

  typedef struct packed {
    logic               style;
    formant_t           formant_index;
    logic               last;
    logic [15:0]        interp_x;
    logic [15:0]        interp_y;
    logic [15:0]        center_blend;
    logic signed [15:0] transpose;
    logic [15:0]        resonance_scale;
  } job_t;

  // corner order: bottom-left, bottom-right, top-left, top-right
  // vowels: A, E, I, O, U
  localparam vowel_t STYLE_TAB [NUM_STYLES][CORNERS] = '{
    '{3'd0, 3'd2, 3'd4, 3'd3},
    '{3'd0, 3'd3, 3'd2, 3'd1}
  };

  localparam val_t VOWEL_GAIN [NUM_VOWELS][NUM_FORMANTS] = '{
    '{-18'sd512, -18'sd2048, -18'sd2304, -18'sd2560},
    '{ 18'sd0,   -18'sd3584, -18'sd1024, -18'sd3584},
    '{ 18'sd0,   -18'sd3840, -18'sd4352, -18'sd5120},
    '{-18'sd512, -18'sd1536, -18'sd3584, -18'sd3584},
    '{ 18'sd0,   -18'sd5120, -18'sd4352, -18'sd3584}
  };

  localparam val_t VOWEL_RES [NUM_VOWELS][NUM_FORMANTS] = '{
    '{18'sd21627, 18'sd24576, 18'sd32768, 18'sd32768},
    '{18'sd21627, 18'sd24576, 18'sd32768, 18'sd32768},
    '{18'sd26214, 18'sd24576, 18'sd32768, 18'sd32768},
    '{18'sd22938, 18'sd24576, 18'sd32768, 18'sd32768},
    '{18'sd22938, 18'sd24576, 18'sd32768, 18'sd32768}
  };

  localparam val_t VOWEL_CUT [NUM_VOWELS][NUM_FORMANTS] = '{
    '{18'sd19393, 18'sd21644, 18'sd25622, 18'sd26021},
    '{18'sd17242, 18'sd23654, 18'sd25537, 18'sd26458},
    '{18'sd15816, 18'sd24077, 18'sd25866, 18'sd26526},
    '{18'sd17242, 18'sd20314, 18'sd25537, 18'sd25866},
    '{18'sd16650, 18'sd19039, 18'sd25705, 18'sd26021}
  };

  // a + floor(((b - a) * t + half) / 2^16)
  function automatic val_t lerp(val_t a, val_t b, logic [FRAC_W-1:0] t);
    logic signed [VAL_W:0]            diff;
    logic signed [VAL_W+FRAC_W+1:0]   prod;
    diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    prod = diff * $signed({1'b0, t});
    prod = prod + (VAL_W+FRAC_W+2)'(1 << (FRAC_W - 1));
    return a + VAL_W'(prod >>> FRAC_W);
  endfunction

endpackage

FILE: hdl/fpi_in_if.sv
// Control update channel.
interface fpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         style;
  logic [15:0]        interp_x;
  logic [15:0]        interp_y;
  logic [15:0]        center_blend;
  logic signed [15:0] transpose;
  logic [15:0]        resonance_scale;

  modport source (output valid, style, interp_x, interp_y, center_blend, transpose,
                  resonance_scale, input ready);
  modport sink (input valid, style, interp_x, interp_y, center_blend, transpose,
                resonance_scale, output ready);
endinterface

FILE: hdl/fpi_out_if.sv
// Formant setting channel.
interface fpi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         formant_index;
  logic signed [16:0] cutoff_note;
  logic [15:0]        resonance;
  logic signed [13:0] gain_db;
  logic               last;

  modport source (output valid, formant_index, cutoff_note, resonance, gain_db, last,
                  input ready);
  modport sink (input valid, formant_index, cutoff_note, resonance, gain_db, last,
                output ready);
endinterface

FILE: hdl/fpi_cfg_if.sv
// Center note register write channel.
interface fpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] center_note;

  modport source (output valid, center_note, input ready);
  modport sink (input valid, center_note, output ready);
endinterface

FILE: hdl/fpi_datapath.sv
// Pipelined bilinear interpolation, blend, scaling and saturation of one formant per word.
module fpi_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  fpi_pkg::job_t    job,
  input  logic [14:0]      center_note,
  output logic             adv,
  fpi_out_if.source        rsp
);

  logic              v1, v2, v3, v4, vo;
  fpi_pkg::job_t     j1, j2, j3, j4;

  fpi_pkg::val_t     cut_bot, cut_top, res_bot, res_top, gain_bot, gain_top;
  fpi_pkg::val_t     cut_y, res_y, gain_y;
  fpi_pkg::val_t     cut_b, gain_3;
  logic [31:0]       rprod;

  fpi_pkg::vowel_t   c0, c1, c2, c3;
  fpi_pkg::val_t     cut_y_next, res_y_next, gain_y_next, cut_b_next;
  fpi_pkg::val_t     center_ext;
  logic [15:0]       res_pos;
  logic signed [18:0] cut_sum;
  logic [17:0]       rround;

  logic [1:0]         o_idx;
  logic signed [16:0] o_cut;
  logic [15:0]        o_res;
  logic signed [13:0] o_gain;
  logic               o_last;

  assign adv = !vo || rsp.ready;

  // corner lookup
  assign c0 = fpi_pkg::STYLE_TAB[j1.style][0];
  assign c1 = fpi_pkg::STYLE_TAB[j1.style][1];
  assign c2 = fpi_pkg::STYLE_TAB[j1.style][2];
  assign c3 = fpi_pkg::STYLE_TAB[j1.style][3];

  assign cut_y_next  = fpi_pkg::lerp(cut_bot, cut_top, j2.interp_y);
  assign res_y_next  = fpi_pkg::lerp(res_bot, res_top, j2.interp_y);
  assign gain_y_next = fpi_pkg::lerp(gain_bot, gain_top, j2.interp_y);

  assign center_ext = fpi_pkg::val_t'({3'b000, center_note});
  assign cut_b_next = fpi_pkg::lerp(cut_y, center_ext, j3.center_blend);
  assign res_pos    = res_y[fpi_pkg::VAL_W-1] ? 16'd0 : res_y[15:0];

  assign cut_sum = 19'(cut_b) + 19'(j4.transpose);
  assign rround  = 18'((33'(rprod) + 33'd16384) >> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else if (adv) begin
      v1 <= job_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vo <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1 <= job;

      j2       <= j1;
      cut_bot  <= fpi_pkg::lerp(fpi_pkg::VOWEL_CUT[c0][j1.formant_index],
                                fpi_pkg::VOWEL_CUT[c1][j1.formant_index], j1.interp_x);
      cut_top  <= fpi_pkg::lerp(fpi_pkg::VOWEL_CUT[c2][j1.formant_index],
                                fpi_pkg::VOWEL_CUT[c3][j1.formant_index], j1.interp_x);
      res_bot  <= fpi_pkg::lerp(fpi_pkg::VOWEL_RES[c0][j1.formant_index],
                                fpi_pkg::VOWEL_RES[c1][j1.formant_index], j1.interp_x);
      res_top  <= fpi_pkg::lerp(fpi_pkg::VOWEL_RES[c2][j1.formant_index],
                                fpi_pkg::VOWEL_RES[c3][j1.formant_index], j1.interp_x);
      gain_bot <= fpi_pkg::lerp(fpi_pkg::VOWEL_GAIN[c0][j1.formant_index],
                                fpi_pkg::VOWEL_GAIN[c1][j1.formant_index], j1.interp_x);
      gain_top <= fpi_pkg::lerp(fpi_pkg::VOWEL_GAIN[c2][j1.formant_index],
                                fpi_pkg::VOWEL_GAIN[c3][j1.formant_index], j1.interp_x);

      j3     <= j2;
      cut_y  <= cut_y_next;
      res_y  <= res_y_next;
      gain_y <= gain_y_next;

      j4     <= j3;
      cut_b  <= cut_b_next;
      gain_3 <= gain_y;
      rprod  <= res_pos * j3.resonance_scale;

      o_idx  <= j4.formant_index;
      o_last <= j4.last;
      o_gain <= gain_3[13:0];
      if (cut_sum > 19'sd65535) begin
        o_cut <= 17'sd65535;
      end else if (cut_sum < -19'sd65536) begin
        o_cut <= -17'sd65536;
      end else begin
        o_cut <= cut_sum[16:0];
      end
      o_res <= (rround > 18'd65535) ? 16'hFFFF : rround[15:0];
    end
  end

  assign rsp.valid         = vo;
  assign rsp.formant_index = o_idx;
  assign rsp.cutoff_note   = o_cut;
  assign rsp.resonance     = o_res;
  assign rsp.gain_db       = o_gain;
  assign rsp.last          = o_last;

endmodule

FILE: hdl/formant_parameter_interpolator.sv
// Formant parameter interpolator top level: update sequencer, center note register, datapath.
// Each accepted control update produces four formant settings, formant 0 to 3, the fourth
// marked last. A sequencer issues one formant per cycle, unless the pipeline stalls, into a
// five-register pipeline (issued word, table lookup and x lerps, y lerps, blend and resonance
// multiply, saturation into the output word), and a new update is accepted in the cycle the
// last formant of the previous one is issued. The center note register resets to note 80 and
// may be written only while no update is in flight.
module formant_parameter_interpolator (
  input  logic       clk,
  input  logic       rst,
  fpi_in_if.sink     req,
  fpi_out_if.source  rsp,
  fpi_cfg_if.sink    cfg
);

  logic                busy;
  fpi_pkg::formant_t   fidx;
  fpi_pkg::job_t       held;
  fpi_pkg::job_t       job;
  logic [14:0]         center_note;
  logic                adv;
  logic                issue;
  logic                accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_note <= fpi_pkg::CENTER_NOTE_RST;
    end else if (cfg.valid) begin
      center_note <= cfg.center_note;
    end
  end

  assign issue     = busy && adv;
  assign req.ready = !busy || (issue && fidx == fpi_pkg::LAST_FORMANT);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fidx <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      fidx <= '0;
    end else if (issue) begin
      busy <= (fidx != fpi_pkg::LAST_FORMANT);
      fidx <= fidx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held.style           <= (req.style != 2'd0);
      held.formant_index   <= '0;
      held.last            <= 1'b0;
      held.interp_x        <= req.interp_x;
      held.interp_y        <= req.interp_y;
      held.center_blend    <= req.center_blend;
      held.transpose       <= req.transpose;
      held.resonance_scale <= req.resonance_scale;
    end
  end

  always_comb begin
    job               = held;
    job.formant_index = fidx;
    job.last          = (fidx == fpi_pkg::LAST_FORMANT);
  end

  fpi_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (busy),
    .job         (job),
    .center_note (center_note),
    .adv         (adv),
    .rsp         (rsp)
  );

endmodule
